/* design/wpwr_pkg.sv */
// Shared types and constants for the weighted pick without replacement unit.
`timescale 1ns / 1ps
package wpwr_pkg;

  // Fixed geometry of the entry list and weights
  localparam int MAX_ENTRIES = 8;
  localparam int WEIGHT_BITS = 8;
  localparam int IDX_W       = 3;
  localparam int CNT_W       = 4;
  localparam int SUM_W       = 11;
  localparam int TABLE_W     = 64;
  localparam int CFG_ADDR_W  = 1;

  // Stream packing
  localparam int S_TDATA_W = 16;
  localparam int S_TUSER_W = 1;
  localparam int M_TDATA_W = 24;
  localparam int M_TUSER_W = 2;

  // Configuration register indexes
  localparam logic [CFG_ADDR_W-1:0] REG_CHILD_COUNT  = 1'd0;
  localparam logic [CFG_ADDR_W-1:0] REG_WEIGHT_TABLE = 1'd1;

  // Item actions
  localparam logic ACT_RESTART = 1'b0;
  localparam logic ACT_PICK    = 1'b1;

  // Result status codes
  typedef enum logic [1:0] {
    ST_PICKED    = 2'd0,
    ST_RESTART   = 2'd1,
    ST_EMPTY     = 2'd2,
    ST_ROLL_HIGH = 2'd3
  } status_t;

  // Controller states
  typedef enum logic {
    S_IDLE = 1'b0,
    S_EVAL = 1'b1
  } state_t;

  // Commands from controller to datapath
  typedef struct packed {
    logic load_item;
    logic eval;
  } cmd_t;

endpackage

/* design/weighted_pick_without_replacement_unit.sv */
// Top level of the weighted pick without replacement unit.
`timescale 1ns / 1ps
// Lottery-style selector over up to eight weighted entries. A restart
// transaction (tuser 0) refills the list with entries 0 to child_count-1
// (at most eight); a pick transaction (tuser 1) takes the first remaining
// entry whose running weight sum reaches the roll and swap-removes it.
// Each input transaction gives exactly one result transaction. An item is
// captured in the idle state; the prefix-sum search and list update run in
// the eval state, during which no new item is accepted. The result waits in
// an output register; the next item may be accepted in the cycle it drains.
// The user must write configuration registers through cfg_we/cfg_addr/cfg_data
// while the block is idle (the block has no guard); weights are read live at pick time.
module weighted_pick_without_replacement_unit (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [wpwr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wpwr_pkg::TABLE_W-1:0]        cfg_data,
  input  logic                                s_tvalid,
  output logic                                s_tready,
  input  logic [wpwr_pkg::S_TDATA_W-1:0]      s_tdata,   // [10:0] roll
  input  logic [wpwr_pkg::S_TUSER_W-1:0]      s_tuser,   // [0] action
  output logic                                m_tvalid,
  input  logic                                m_tready,
  // [2:0] chosen_entry, [13:3] remaining_total, [17:14] remaining_count
  output logic [wpwr_pkg::M_TDATA_W-1:0]      m_tdata,
  output logic [wpwr_pkg::M_TUSER_W-1:0]      m_tuser    // [1:0] status
);
  import wpwr_pkg::*;

  cmd_t             cmd;
  logic [IDX_W-1:0] out_chosen;
  logic [SUM_W-1:0] out_total;
  logic [CNT_W-1:0] out_count;
  status_t          out_status;

  wpwr_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .cmd      (cmd)
  );

  wpwr_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cmd        (cmd),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_data   (cfg_data),
    .in_action  (s_tuser[0]),
    .in_roll    (s_tdata[SUM_W-1:0]),
    .out_chosen (out_chosen),
    .out_total  (out_total),
    .out_count  (out_count),
    .out_status (out_status)
  );

  // Pack the result fields, lowest field first
  assign m_tdata = {{(M_TDATA_W - IDX_W - SUM_W - CNT_W){1'b0}},
                    out_count, out_total, out_chosen};
  assign m_tuser = out_status;

endmodule

/* design/wpwr_ctrl.sv */
// Controller state machine: input/output handshakes and datapath sequencing.
`timescale 1ns / 1ps
module wpwr_ctrl (
  input  logic            clk,
  input  logic            rst,
  input  logic            s_tvalid,
  output logic            s_tready,
  output logic            m_tvalid,
  input  logic            m_tready,
  output wpwr_pkg::cmd_t  cmd
);
  import wpwr_pkg::*;

  state_t state;
  state_t state_next;
  logic   out_valid;
  logic   out_valid_next;
  logic   accept;

  // Take a new transaction only when idle and the result slot is free or draining
  assign s_tready = (state == S_IDLE) && (!out_valid || m_tready);
  assign accept   = s_tvalid && s_tready;
  assign m_tvalid = out_valid;

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept) begin
          state_next = S_EVAL;
        end
      end
      S_EVAL: begin
        state_next = S_IDLE;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Outputs and result-valid tracking
  always_comb begin
    cmd.load_item  = 1'b0;
    cmd.eval       = 1'b0;
    out_valid_next = out_valid;
    if (out_valid && m_tready) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        cmd.load_item = accept;
      end
      S_EVAL: begin
        cmd.eval       = 1'b1;
        out_valid_next = 1'b1;
      end
      default: begin
        cmd.load_item = 1'b0;
      end
    endcase
  end

  // Hold state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

endmodule

/* design/wpwr_dp.sv */
// Datapath: configuration, remaining list, prefix-sum search and result register.
`timescale 1ns / 1ps
module wpwr_dp (
  input  logic                                clk,
  input  logic                                rst,
  input  wpwr_pkg::cmd_t                      cmd,
  input  logic                                cfg_we,
  input  logic [wpwr_pkg::CFG_ADDR_W-1:0]     cfg_addr,
  input  logic [wpwr_pkg::TABLE_W-1:0]        cfg_data,
  input  logic                                in_action,
  input  logic [wpwr_pkg::SUM_W-1:0]          in_roll,
  output logic [wpwr_pkg::IDX_W-1:0]          out_chosen,
  output logic [wpwr_pkg::SUM_W-1:0]          out_total,
  output logic [wpwr_pkg::CNT_W-1:0]          out_count,
  output wpwr_pkg::status_t                   out_status
);
  import wpwr_pkg::*;

  logic [CNT_W-1:0]       child_count;
  logic [TABLE_W-1:0]     weight_table;
  logic [IDX_W-1:0]       remaining_list [MAX_ENTRIES];
  logic [CNT_W-1:0]       list_length;
  logic [SUM_W-1:0]       weight_sum;
  logic                   item_action;
  logic [SUM_W-1:0]       item_roll;

  logic [WEIGHT_BITS-1:0] lane_w   [MAX_ENTRIES];
  logic [SUM_W-1:0]       run_sum  [MAX_ENTRIES];
  logic [MAX_ENTRIES-1:0] hit;
  logic                   found;
  logic [IDX_W-1:0]       pos;
  logic [CNT_W-1:0]       last;
  logic [CNT_W-1:0]       fill_count;
  logic [SUM_W-1:0]       fill_sum;
  logic [WEIGHT_BITS-1:0] pick_w;
  logic                   do_pick;
  logic [SUM_W-1:0]       weight_sum_next;
  logic [CNT_W-1:0]       list_length_next;
  logic [IDX_W-1:0]       chosen_next;
  status_t                status_next;

  function automatic logic [WEIGHT_BITS-1:0] weight_of(
    input logic [TABLE_W-1:0] tbl,
    input logic [IDX_W-1:0]   idx
  );
    weight_of = tbl[idx * WEIGHT_BITS +: WEIGHT_BITS];
  endfunction

  // Configuration writes
  always_ff @(posedge clk) begin
    if (rst) begin
      child_count  <= '0;
      weight_table <= '0;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        REG_CHILD_COUNT:  child_count  <= cfg_data[CNT_W-1:0];
        REG_WEIGHT_TABLE: weight_table <= cfg_data;
        default:          child_count  <= child_count;
      endcase
    end
  end

  // Capture the accepted transaction
  always_ff @(posedge clk) begin
    if (cmd.load_item) begin
      item_action <= in_action;
      item_roll   <= in_roll;
    end
  end

  // Running weight sums along the remaining list
  always_comb begin
    logic [SUM_W-1:0] acc;
    acc = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      lane_w[i]  = weight_of(weight_table, remaining_list[i]);
      acc        = acc + SUM_W'(lane_w[i]);
      run_sum[i] = acc;
      hit[i]     = (CNT_W'(i) < list_length) && (run_sum[i] >= item_roll);
    end
  end

  // Find the first lane whose running sum reaches the roll
  always_comb begin
    found = 1'b0;
    pos   = '0;
    for (int i = MAX_ENTRIES - 1; i >= 0; i--) begin
      if (hit[i]) begin
        found = 1'b1;
        pos   = IDX_W'(i);
      end
    end
  end

  // Refill count and total for a restart
  always_comb begin
    logic [SUM_W-1:0] acc;
    fill_count = (child_count > CNT_W'(MAX_ENTRIES)) ? CNT_W'(MAX_ENTRIES) : child_count;
    acc = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) begin
      if (CNT_W'(i) < fill_count) begin
        acc = acc + SUM_W'(weight_of(weight_table, IDX_W'(i)));
      end
    end
    fill_sum = acc;
  end

  assign last   = list_length - CNT_W'(1);
  assign pick_w = lane_w[pos];

  // Decide the item's outcome
  always_comb begin
    weight_sum_next  = weight_sum;
    list_length_next = list_length;
    chosen_next      = '0;
    do_pick          = 1'b0;
    status_next      = ST_ROLL_HIGH;
    priority if (item_action == ACT_RESTART) begin
      weight_sum_next  = fill_sum;
      list_length_next = fill_count;
      status_next      = ST_RESTART;
    end else if (list_length == '0) begin
      status_next = ST_EMPTY;
    end else if (item_roll > weight_sum) begin
      status_next = ST_ROLL_HIGH;
    end else if (found) begin
      do_pick          = 1'b1;
      chosen_next      = remaining_list[pos];
      weight_sum_next  = (SUM_W'(pick_w) > weight_sum) ? '0 : weight_sum - SUM_W'(pick_w);
      list_length_next = last;
      status_next      = ST_PICKED;
    end else begin
      status_next = ST_ROLL_HIGH;
    end
  end

  // Update list state
  always_ff @(posedge clk) begin
    if (rst) begin
      list_length <= '0;
      weight_sum  <= '0;
    end else if (cmd.eval) begin
      list_length <= list_length_next;
      weight_sum  <= weight_sum_next;
    end
  end

  // Refill in order, or swap-remove the picked slot with the last one
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      if (item_action == ACT_RESTART) begin
        for (int i = 0; i < MAX_ENTRIES; i++) begin
          remaining_list[i] <= IDX_W'(i);
        end
      end else if (do_pick) begin
        remaining_list[pos] <= remaining_list[last[IDX_W-1:0]];
      end
    end
  end

  // Result register
  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      out_chosen <= chosen_next;
      out_total  <= weight_sum_next;
      out_count  <= list_length_next;
      out_status <= status_next;
    end
  end

endmodule
